### hdl/sse_pkg.sv
// Package for the sorted store with ordered extraction.
// Holds the request and response types, the opcode and status codes and the cell control struct.
// Depends on nothing; every other file of the block uses it.
package sse_pkg;

   // Default number of entries in the store.
   localparam int DEFAULT_CAPACITY = 64;

   // Width of counts and positions inside the cell row, wide enough for the largest store.
   localparam int CNT_W = 11;

   // Request opcodes.
   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_END    = 2'd1,
      OP_AT     = 2'd2,
      OP_MEDIAN = 2'd3
   } opcode_type;

   // Response status codes.
   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2,
      ST_RANGE = 2'd3
   } status_type;

   // What the cell row does: hold, insert or remove.
   typedef enum logic [1:0] {
      MODE_HOLD   = 2'd0,
      MODE_INSERT = 2'd1,
      MODE_REMOVE = 2'd2
   } mode_type;

   // One request.
   typedef struct packed {
      opcode_type         opcode;
      logic signed [31:0] task_value;
      logic               take_smallest;
      logic [5:0]         position;
   } req_type;

   // One response.
   typedef struct packed {
      logic signed [31:0] removed_id;
      logic [5:0]         removed_index;
      logic [6:0]         count_left;
      status_type         status;
   } rsp_type;

   // Control broadcast to every cell.
   typedef struct packed {
      mode_type           mode;
      logic signed [31:0] value;
      logic [CNT_W-1:0]   count;
      logic [CNT_W-1:0]   sel;
   } cell_ctrl_type;

endpackage

### hdl/sorted_store_order_extract.sv
// Top level of the sorted store with ordered extraction.
// Depends on sse_pkg and instantiates one sse_cell per entry.
//
// The block keeps signed 32-bit task IDs in ascending order in a row of cells, one entry per
// cell, and takes one request in every clock cycle: busy stays low. Each request gives exactly
// one response on rsp_data, marked by rsp_strobe for one cycle, after the request capture and
// response registers; the receiver must take it in that cycle. The rate is set by the cell
// row, where every cell compares and shifts in parallel, so the next request already sees the
// store that the previous one left. Removed IDs are gathered from the cells by a one-hot
// select; error responses carry zero in removed_id and removed_index.
module sorted_store_order_extract #(
   parameter int CAPACITY = sse_pkg::DEFAULT_CAPACITY
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  sse_pkg::req_type req_data,
   output logic             rsp_strobe,
   output sse_pkg::rsp_type rsp_data
);

   localparam int CW       = sse_pkg::CNT_W;
   localparam int CNT_BITS = $clog2(CAPACITY + 1);

   sse_pkg::req_type       req_ff;
   logic                   req_valid_ff;
   logic [CNT_BITS-1:0]    count_ff;
   logic [CNT_BITS-1:0]    count_in;
   logic                   rsp_strobe_ff;
   sse_pkg::rsp_type       rsp_ff;
   sse_pkg::rsp_type       rsp_in;
   sse_pkg::cell_ctrl_type ctrl;
   logic [CW-1:0]          count_w;
   logic [CW-1:0]          k;
   logic signed [31:0]     picked;

   logic signed [31:0]     entries  [CAPACITY];
   logic                   greaters [CAPACITY];
   logic                   hits     [CAPACITY];

   assign busy = 1'b0;

   // Request capture stage.
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= start && !busy;
      end
      req_ff <= req_data;
   end

   // Position that a removal targets.
   assign count_w = CW'(count_ff);
   always_comb begin
      unique case (req_ff.opcode)
         sse_pkg::OP_END:    k = req_ff.take_smallest ? '0 : count_w - CW'(1);
         sse_pkg::OP_AT:     k = CW'(req_ff.position);
         sse_pkg::OP_MEDIAN: k = count_w >> 1;
         default:            k = '0;
      endcase
   end

   // The entry at the removal position, picked from the row by its one-hot hit flags.
   always_comb begin
      picked = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         picked = picked | (hits[i] ? entries[i] : 32'sd0);
      end
   end

   // Decide the cell operation, the new count and the response.
   always_comb begin
      ctrl.mode            = sse_pkg::MODE_HOLD;
      ctrl.value           = req_ff.task_value;
      ctrl.count           = count_w;
      ctrl.sel             = k;
      count_in             = count_ff;
      rsp_in.removed_id    = '0;
      rsp_in.removed_index = '0;
      rsp_in.status        = sse_pkg::ST_OK;
      priority if (!req_valid_ff) begin
         ctrl.mode = sse_pkg::MODE_HOLD;
      end else if (req_ff.opcode == sse_pkg::OP_INSERT) begin
         if (count_w >= CW'(CAPACITY)) begin
            rsp_in.status = sse_pkg::ST_FULL;
         end else begin
            ctrl.mode = sse_pkg::MODE_INSERT;
            count_in  = count_ff + CNT_BITS'(1);
         end
      end else if (count_ff == '0) begin
         rsp_in.status = sse_pkg::ST_EMPTY;
      end else if (k >= count_w) begin
         rsp_in.status = sse_pkg::ST_RANGE;
      end else begin
         ctrl.mode            = sse_pkg::MODE_REMOVE;
         count_in             = count_ff - CNT_BITS'(1);
         rsp_in.removed_id    = picked;
         rsp_in.removed_index = k[5:0];
      end
      rsp_in.count_left = 7'(count_in);
   end

   // Count and response registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         count_ff      <= count_in;
         rsp_strobe_ff <= req_valid_ff;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

   // The row of cells, each linked to its two neighbors.
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic signed [31:0] left_entry;
      logic               left_greater;
      logic signed [31:0] right_entry;

      if (i == 0) begin : g_first
         assign left_entry   = '0;
         assign left_greater = 1'b0;
      end else begin : g_inner
         assign left_entry   = entries[i-1];
         assign left_greater = greaters[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign right_entry = '0;
      end else begin : g_body
         assign right_entry = entries[i+1];
      end

      sse_cell #(
         .INDEX(i)
      ) u_cell (
         .clock        (clock),
         .ctrl         (ctrl),
         .left_entry   (left_entry),
         .left_greater (left_greater),
         .right_entry  (right_entry),
         .entry        (entries[i]),
         .greater      (greaters[i]),
         .hit          (hits[i])
      );
   end

endmodule

### hdl/sse_cell.sv
// One cell of the sorted store: holds a single entry and trades it with its neighbors.
// Depends on sse_pkg for the cell control struct and mode codes.
module sse_cell #(
   parameter int INDEX = 0
) (
   input  logic                  clock,
   input  sse_pkg::cell_ctrl_type ctrl,
   input  logic signed [31:0]    left_entry,
   input  logic                  left_greater,
   input  logic signed [31:0]    right_entry,
   output logic signed [31:0]    entry,
   output logic                  greater,
   output logic                  hit
);

   logic signed [31:0] entry_ff;
   logic signed [31:0] entry_in;
   logic               at_or_past_end;
   logic               at_or_past_sel;

   // Positional flags against the current count and the removal position.
   assign at_or_past_end = (sse_pkg::CNT_W'(INDEX) >= ctrl.count);
   assign at_or_past_sel = (sse_pkg::CNT_W'(INDEX) >= ctrl.sel);

   // An empty slot counts as greater than any value, which keeps the flags monotone.
   assign greater = at_or_past_end || (entry_ff > ctrl.value);
   assign hit     = (sse_pkg::CNT_W'(INDEX) == ctrl.sel);
   assign entry   = entry_ff;

   // Insert shifts right from the first greater cell; remove shifts left from the position.
   always_comb begin
      entry_in = entry_ff;
      unique case (ctrl.mode)
         sse_pkg::MODE_INSERT: begin
            if (greater) begin
               entry_in = left_greater ? left_entry : ctrl.value;
            end
         end
         sse_pkg::MODE_REMOVE: begin
            if (at_or_past_sel) begin
               entry_in = right_entry;
            end
         end
         default: begin
            entry_in = entry_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

### hdl/sse_checker.sv
// Port-level checker for the sorted store, attached to the top level by a bind statement.
// Depends on sse_pkg for the response type and status codes.
module sse_checker (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input logic             rsp_strobe,
   input sse_pkg::rsp_type rsp_data
);

   // Every accepted request gives a response, after the request capture and response registers.
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      (!reset && start && !busy) |=> ##1 rsp_strobe)
      else $error("accepted request gave no response");

   // No response appears without a request accepted ahead of it through those same registers.
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      !(start && !busy) |=> ##1 !rsp_strobe)
      else $error("response without a request");

   // An error response carries no removed entry.
   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.status != sse_pkg::ST_OK)
         |-> (rsp_data.removed_id == 32'sd0 && rsp_data.removed_index == 6'd0))
      else $error("error response carries a removed entry");

   // An empty-store response leaves the count at zero.
   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.status == sse_pkg::ST_EMPTY) |-> (rsp_data.count_left == 7'd0))
      else $error("empty-store response with a nonzero count");

   // Requests are never held off while reset is low.
   a_never_busy: assert property (@(posedge clock) disable iff (reset) !busy)
      else $error("busy raised");

endmodule

bind sorted_store_order_extract sse_checker u_sse_checker (.*);

### verif/tb.sv
// Testbench for sorted_store_order_extract: directed and random requests against a behavioral
// model of the sorted task store, with every response checked field by field.
// Depends on sse_pkg and the RTL of the block.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int STORE_DEPTH  = sse_pkg::DEFAULT_CAPACITY;
   localparam int RANDOM_ITEMS = 1380;
   localparam int STALL_LIMIT  = 2000;
   localparam int DRAIN_CYCLES = 8;
   localparam int REQ_W        = $bits(sse_pkg::req_type);

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             start = 1'b0;
   logic             busy;
   sse_pkg::req_type req_data = '0;
   logic             rsp_strobe;
   sse_pkg::rsp_type rsp_data;

   // Behavioral copy of the store, ascending, duplicates after their equals.
   logic signed [31:0] model_ids[$];
   sse_pkg::req_type   pending_req[$];
   sse_pkg::rsp_type   expected_rsp[$];
   sse_pkg::rsp_type   want_rsp;

   int          gen_count = 0;
   int unsigned gap_left = 0;
   int unsigned calm_left = 0;
   int unsigned idle_cycles = 0;
   int          errors = 0;

   sorted_store_order_extract i_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   always #5 clock = ~clock;

   // Applies one request to the model store and returns the response it must give.
   function automatic sse_pkg::rsp_type predict_response(sse_pkg::req_type r);
      sse_pkg::rsp_type res;
      int unsigned      k;
      int unsigned      n;
      res = '0;
      res.status = sse_pkg::ST_OK;
      n = model_ids.size();
      if (r.opcode == sse_pkg::OP_INSERT) begin
         if (n >= STORE_DEPTH) begin
            res.status = sse_pkg::ST_FULL;
         end else begin
            k = 0;
            while (k < n && $signed(model_ids[k]) <= $signed(r.task_value)) k++;
            model_ids.insert(k, r.task_value);
         end
      end else if (n == 0) begin
         res.status = sse_pkg::ST_EMPTY;
      end else begin
         case (r.opcode)
            sse_pkg::OP_END: k = r.take_smallest ? 0 : n - 1;
            sse_pkg::OP_AT:  k = 32'(r.position);
            default:         k = n / 2;
         endcase
         if (k >= n) begin
            res.status = sse_pkg::ST_RANGE;
         end else begin
            res.removed_id    = model_ids[k];
            res.removed_index = 6'(k);
            model_ids.delete(k);
         end
      end
      res.count_left = 7'(model_ids.size());
      return res;
   endfunction

   // Short gaps mostly, now and then a long one.
   function automatic int unsigned pick_gap();
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 55) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // IDs: full range, a narrow band that makes duplicates, or an extreme.
   function automatic logic signed [31:0] pick_id();
      int unsigned roll;
      roll = $urandom_range(9);
      if (roll < 5) return $urandom();
      if (roll < 8) return int'($urandom_range(16)) - 8;
      case ($urandom_range(3))
         0:       return 32'h7FFF_FFFF;
         1:       return 32'h8000_0000;
         2:       return 32'h0000_0000;
         default: return 32'hFFFF_FFFF;
      endcase
   endfunction

   // Queues one request and tracks the store fill level the generator expects.
   task automatic push_item(sse_pkg::req_type r);
      pending_req.insert(pending_req.size(), r);
      if (r.opcode == sse_pkg::OP_INSERT) begin
         if (gen_count < STORE_DEPTH) gen_count++;
      end else if (gen_count > 0 &&
                   !(r.opcode == sse_pkg::OP_AT && int'(r.position) >= gen_count)) begin
         gen_count--;
      end
   endtask

   task automatic queue_request(sse_pkg::opcode_type op, logic signed [31:0] value,
                                logic smallest, logic [5:0] pos);
      sse_pkg::req_type r;
      r.opcode        = op;
      r.task_value    = value;
      r.take_smallest = smallest;
      r.position      = pos;
      push_item(r);
   endtask

   // Removal request with random content, the position usually inside the store.
   task automatic queue_removal();
      sse_pkg::opcode_type op;
      logic [5:0]          pos;
      case ($urandom_range(2))
         0:       op = sse_pkg::OP_END;
         1:       op = sse_pkg::OP_AT;
         default: op = sse_pkg::OP_MEDIAN;
      endcase
      if (gen_count > 0 && $urandom_range(9) < 8) pos = 6'($urandom_range(gen_count - 1));
      else pos = 6'($urandom_range(63));
      queue_request(op, $urandom(), 1'($urandom_range(1)), pos);
   endtask

   // Request driver: one request per handshake, with random gaps between them.
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            expected_rsp.insert(expected_rsp.size(), predict_response(req_data));
         end
         if (!(start && busy)) begin
            if (gap_left > 0) begin
               gap_left--;
               start <= 1'b0;
            end else if (pending_req.size() != 0) begin
               req_data <= pending_req.pop_front();
               start    <= 1'b1;
               if (calm_left > 0) begin
                  calm_left--;
                  gap_left = 0;
               end else begin
                  gap_left = pick_gap();
                  if ($urandom_range(39) == 0) calm_left = $urandom_range(30, 150);
               end
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // Response monitor: each strobe is matched against the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (expected_rsp.size() == 0) begin
            $error("response with no request outstanding: removed_id %0d status %0d",
                   rsp_data.removed_id, rsp_data.status);
            errors++;
         end else begin
            want_rsp = expected_rsp.pop_front();
            if (rsp_data.removed_id !== want_rsp.removed_id) begin
               $error("removed_id: expected %0d, actual %0d",
                      want_rsp.removed_id, rsp_data.removed_id);
               errors++;
            end
            if (rsp_data.removed_index !== want_rsp.removed_index) begin
               $error("removed_index: expected %0d, actual %0d",
                      want_rsp.removed_index, rsp_data.removed_index);
               errors++;
            end
            if (rsp_data.count_left !== want_rsp.count_left) begin
               $error("count_left: expected %0d, actual %0d",
                      want_rsp.count_left, rsp_data.count_left);
               errors++;
            end
            if (rsp_data.status !== want_rsp.status) begin
               $error("status: expected %0d, actual %0d", want_rsp.status, rsp_data.status);
               errors++;
            end
         end
      end
   end

   // Watchdog: too long without any request or response accepted ends the run.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles == STALL_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

   initial begin : stimulus
      int               ins_pct;
      int               episode_len;
      int               episode;
      int               target;
      sse_pkg::req_type noise;

      // Removals of every kind from the empty store.
      queue_request(sse_pkg::OP_END, 32'h1234_5678, 1'b1, 6'd0);
      queue_request(sse_pkg::OP_END, 32'hFFFF_FFFF, 1'b0, 6'd63);
      queue_request(sse_pkg::OP_AT, 32'h0, 1'b0, 6'd0);
      queue_request(sse_pkg::OP_MEDIAN, 32'h8000_0000, 1'b1, 6'd21);
      // Extreme IDs and a duplicate, which must land after its equal.
      queue_request(sse_pkg::OP_INSERT, 32'h7FFF_FFFF, 1'b0, 6'd0);
      queue_request(sse_pkg::OP_INSERT, 32'h8000_0000, 1'b1, 6'd63);
      queue_request(sse_pkg::OP_INSERT, 32'h0000_0000, 1'b0, 6'd0);
      queue_request(sse_pkg::OP_INSERT, 32'hFFFF_FFFF, 1'b1, 6'd42);
      queue_request(sse_pkg::OP_INSERT, 32'd5, 1'b0, 6'd0);
      queue_request(sse_pkg::OP_INSERT, 32'd5, 1'b1, 6'd0);
      queue_request(sse_pkg::OP_INSERT, 32'd1, 1'b0, 6'd0);
      // Positions past the end, then the last valid one.
      queue_request(sse_pkg::OP_AT, 32'h0, 1'b0, 6'd63);
      queue_request(sse_pkg::OP_AT, 32'h0, 1'b0, 6'd7);
      queue_request(sse_pkg::OP_MEDIAN, 32'h0, 1'b0, 6'd0);
      queue_request(sse_pkg::OP_AT, 32'h0, 1'b0, 6'd5);
      queue_request(sse_pkg::OP_END, 32'h0, 1'b1, 6'd0);
      queue_request(sse_pkg::OP_END, 32'h0, 1'b0, 6'd0);
      queue_request(sse_pkg::OP_MEDIAN, 32'h0, 1'b1, 6'd0);
      queue_request(sse_pkg::OP_AT, 32'h0, 1'b0, 6'd0);
      queue_request(sse_pkg::OP_END, 32'h0, 1'b1, 6'd0);
      queue_request(sse_pkg::OP_END, 32'h0, 1'b0, 6'd0);

      // Random episodes: a forced fill past full, a forced drain past empty, then mixed
      // episodes leaning toward fill, drain, balance or raw noise.
      target  = pending_req.size() + RANDOM_ITEMS;
      episode = 0;
      while (pending_req.size() < target) begin
         if (episode == 0) begin
            ins_pct     = 100;
            episode_len = STORE_DEPTH + 6;
         end else if (episode == 1) begin
            ins_pct     = 0;
            episode_len = STORE_DEPTH + 6;
         end else begin
            case ($urandom_range(3))
               0:       ins_pct = 85;
               1:       ins_pct = 15;
               2:       ins_pct = 50;
               default: ins_pct = -50;
            endcase
            episode_len = $urandom_range(20, 150);
         end
         repeat (episode_len) begin
            if (ins_pct < 0 && $urandom_range(9) < 3) begin
               noise = REQ_W'({$urandom(), $urandom()});
               push_item(noise);
            end else if ($urandom_range(99) < (ins_pct < 0 ? 50 : ins_pct)) begin
               queue_request(sse_pkg::OP_INSERT, pick_id(), 1'($urandom_range(1)),
                             6'($urandom_range(63)));
            end else begin
               queue_removal();
            end
         end
         episode++;
      end

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Let every request go out, every response come back, then watch for strays.
      while (pending_req.size() != 0 || start) @(posedge clock);
      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (errors == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
